[design/tlvfr_pkg.sv]
// ----------------------------------------------------------------------------
// tlvfr_pkg: shared types and constants for the TLV frame receiver
// Sizes of the value store, field widths and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package tlvfr_pkg;

    // Value store depth and derived widths
    localparam int MAX_VALUE_BYTES = 32;
    localparam int ADDR_W          = (MAX_VALUE_BYTES > 1) ? $clog2(MAX_VALUE_BYTES) : 1;
    localparam int LEN_W           = 6;
    localparam int DATA_W          = 8;
    localparam int IDX_W           = 5;

    // Largest length byte ever taken: store depth capped by the result budget
    localparam int RESULT_BUDGET   = 32;
    localparam int ACCEPT_CAP      = (MAX_VALUE_BYTES < RESULT_BUDGET) ?
                                     MAX_VALUE_BYTES : RESULT_BUDGET;

    // Reset value of max_length
    localparam logic [LEN_W-1:0] MAX_LENGTH_RST = LEN_W'(32);

    // Controller -> datapath commands
    typedef struct packed {
        logic cap_type;    // latch type byte
        logic cap_len;     // latch length byte, clear fill count
        logic store_byte;  // write value byte into the store
        logic emit_start;  // rewind emit index, prefetch entry 0
        logic emit_load;   // load one value result into the output register
        logic zero_load;   // load the zero-length result
    } tlvfr_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic len_ok;      // incoming length byte within limit
        logic len_zero;    // incoming length byte is zero
        logic fill_done;   // this value byte completes the frame
        logic fill_below;  // fill count below held length
        logic out_free;    // output register can take a word this cycle
        logic emit_last;   // emit index is at the final value byte
    } tlvfr_sts_t;

endpackage

[design/tlvfr_ctrl.sv]
// ----------------------------------------------------------------------------
// tlvfr_ctrl: frame parser state machine
// Walks type, length and value phases, then drives the store drain.
// ----------------------------------------------------------------------------
module tlvfr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tlvfr_pkg::tlvfr_sts_t sts,
    output tlvfr_pkg::tlvfr_cmd_t cmd
);

    localparam logic [2:0] S_TYPE  = 3'd0;
    localparam logic [2:0] S_LEN   = 3'd1;
    localparam logic [2:0] S_VALUE = 3'd2;
    localparam logic [2:0] S_PRIME = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_ZERO  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_TYPE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_TYPE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.cap_type = 1'b1;
                    state_next   = S_LEN;
                end
            end
            S_LEN:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (!sts.len_ok)
                    begin
                        state_next = S_TYPE;  // oversize: drop the frame
                    end
                    else
                    begin
                        cmd.cap_len = 1'b1;
                        state_next  = sts.len_zero ? S_ZERO : S_VALUE;
                    end
                end
            end
            S_VALUE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.store_byte = 1'b1;
                    if (sts.fill_done)
                    begin
                        state_next = S_PRIME;
                    end
                end
            end
            S_PRIME:
            begin
                cmd.emit_start = 1'b1;
                state_next     = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    if (sts.emit_last)
                    begin
                        state_next = S_TYPE;
                    end
                end
            end
            S_ZERO:
            begin
                if (sts.out_free)
                begin
                    cmd.zero_load = 1'b1;
                    state_next    = S_TYPE;
                end
            end
            default:
            begin
                state_next = S_TYPE;
            end
        endcase
    end

endmodule

[design/tlvfr_datapath.sv]
// ----------------------------------------------------------------------------
// tlvfr_datapath: frame registers, value store and output register
// Holds type/length, fills the store, drains it one word per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module tlvfr_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [tlvfr_pkg::LEN_W-1:0]         cfg_data,
    input  logic [tlvfr_pkg::DATA_W-1:0]        rx_data,
    input  tlvfr_pkg::tlvfr_cmd_t               cmd,
    output tlvfr_pkg::tlvfr_sts_t               sts,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tlvfr_pkg::DATA_W-1:0]        frame_type,
    output logic [tlvfr_pkg::LEN_W-1:0]         frame_length,
    output logic [tlvfr_pkg::IDX_W-1:0]         byte_index,
    output logic [tlvfr_pkg::DATA_W-1:0]        value_byte,
    output logic                                has_value,
    output logic                                last
);

    localparam int LEN_W  = tlvfr_pkg::LEN_W;
    localparam int DATA_W = tlvfr_pkg::DATA_W;
    localparam int IDX_W  = tlvfr_pkg::IDX_W;
    localparam int ADDR_W = tlvfr_pkg::ADDR_W;

    logic [LEN_W-1:0]  max_length_reg;
    logic [DATA_W-1:0] held_type_reg;
    logic [LEN_W-1:0]  held_length_reg;
    logic [LEN_W-1:0]  fill_count_reg;
    logic [IDX_W-1:0]  emit_idx_reg;
    logic [IDX_W-1:0]  emit_idx_next;
    logic [DATA_W-1:0] rd_data_reg;
    logic [DATA_W-1:0] value_mem [tlvfr_pkg::MAX_VALUE_BYTES];

    logic              out_valid_reg;
    logic [DATA_W-1:0] frame_type_reg;
    logic [LEN_W-1:0]  frame_length_reg;
    logic [IDX_W-1:0]  byte_index_reg;
    logic [DATA_W-1:0] value_byte_reg;
    logic              has_value_reg;
    logic              last_reg;

    logic [LEN_W-1:0]  accept_limit;
    logic [LEN_W-1:0]  fill_inc;
    logic [LEN_W-1:0]  emit_inc;

    // Length limit: smaller of max_length and the fixed cap
    assign accept_limit = (max_length_reg > LEN_W'(tlvfr_pkg::ACCEPT_CAP)) ?
                          LEN_W'(tlvfr_pkg::ACCEPT_CAP) : max_length_reg;
    assign fill_inc     = fill_count_reg + LEN_W'(1);
    assign emit_inc     = LEN_W'(emit_idx_reg) + LEN_W'(1);

    // Status to controller
    always_comb
    begin
        sts.len_ok     = ({{(DATA_W-LEN_W){1'b0}}, accept_limit} >= rx_data);
        sts.len_zero   = (rx_data == '0);
        sts.fill_done  = (fill_inc == held_length_reg);
        sts.fill_below = (fill_count_reg < held_length_reg);
        sts.out_free   = !out_valid_reg || out_ready;
        sts.emit_last  = (emit_inc == held_length_reg);
    end

    // Config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= tlvfr_pkg::MAX_LENGTH_RST;
        end
        else if (cfg_write)
        begin
            max_length_reg <= cfg_data;
        end
    end

    // Frame header and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_type_reg   <= '0;
            held_length_reg <= '0;
            fill_count_reg  <= '0;
        end
        else
        begin
            if (cmd.cap_type)
            begin
                held_type_reg <= rx_data;
            end
            if (cmd.cap_len)
            begin
                held_length_reg <= rx_data[LEN_W-1:0];
                fill_count_reg  <= '0;
            end
            else if (cmd.store_byte)
            begin
                fill_count_reg <= fill_inc;
            end
        end
    end

    // Emit index; read address runs one step ahead of the registered data
    always_comb
    begin
        priority if (cmd.emit_start)
        begin
            emit_idx_next = '0;
        end
        else if (cmd.emit_load)
        begin
            emit_idx_next = emit_idx_reg + IDX_W'(1);
        end
        else
        begin
            emit_idx_next = emit_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_idx_reg <= '0;
        end
        else
        begin
            emit_idx_reg <= emit_idx_next;
        end
    end

    // Value store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.store_byte)
        begin
            value_mem[fill_count_reg[ADDR_W-1:0]] <= rx_data;
        end
        rd_data_reg <= value_mem[emit_idx_next[ADDR_W-1:0]];
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_load || cmd.zero_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            frame_type_reg   <= held_type_reg;
            frame_length_reg <= held_length_reg;
            byte_index_reg   <= emit_idx_reg;
            value_byte_reg   <= rd_data_reg;
            has_value_reg    <= 1'b1;
            last_reg         <= sts.emit_last;
        end
        else if (cmd.zero_load)
        begin
            frame_type_reg   <= held_type_reg;
            frame_length_reg <= '0;
            byte_index_reg   <= '0;
            value_byte_reg   <= '0;
            has_value_reg    <= 1'b0;
            last_reg         <= 1'b1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_type   = frame_type_reg;
    assign frame_length = frame_length_reg;
    assign byte_index   = byte_index_reg;
    assign value_byte   = value_byte_reg;
    assign has_value    = has_value_reg;
    assign last         = last_reg;

endmodule

[design/tlv_frame_receiver.sv]
// Latency: after a frame's last value byte is taken, the parser passes S_PRIME
//   (prefetch of entry 0) and then S_EMIT, which loads the first result once the
//   output register has room (S_ZERO does so after the length byte of a zero-length frame).
// Throughput: one input byte per cycle while parsing; the store then drains at
//   one result word per cycle unless the output stalls, with input held off meanwhile.
// Reset: rst_n clears parser state, header registers and output valid at once.
// ----------------------------------------------------------------------------
// tlv_frame_receiver: type-length-value frame receiver
// Parses type, length and value bytes and replays each accepted frame as result words.
// ----------------------------------------------------------------------------
module tlv_frame_receiver (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [tlvfr_pkg::LEN_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [tlvfr_pkg::DATA_W-1:0]        rx_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tlvfr_pkg::DATA_W-1:0]        frame_type,
    output logic [tlvfr_pkg::LEN_W-1:0]         frame_length,
    output logic [tlvfr_pkg::IDX_W-1:0]         byte_index,
    output logic [tlvfr_pkg::DATA_W-1:0]        value_byte,
    output logic                                has_value,
    output logic                                last
);

    tlvfr_pkg::tlvfr_cmd_t cmd;
    tlvfr_pkg::tlvfr_sts_t sts;

    // Parser controller
    tlvfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Header, store and output datapath
    tlvfr_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .rx_data      (rx_data),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .frame_type   (frame_type),
        .frame_length (frame_length),
        .byte_index   (byte_index),
        .value_byte   (value_byte),
        .has_value    (has_value),
        .last         (last)
    );

    // Input is never taken while the store drains
    a_no_input_while_emit: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd.emit_load || cmd.zero_load || cmd.emit_start) |-> !in_ready
    ) else $error("input ready during frame emission");

    // A result is loaded only when the output register has room
    a_load_needs_room: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd.emit_load || cmd.zero_load) |-> sts.out_free
    ) else $error("output register overwritten");

    // Value bytes never run past the held length
    a_fill_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.store_byte |-> sts.fill_below
    ) else $error("value byte beyond frame length");

    // A loaded result is visible on the next cycle
    a_load_shows: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd.emit_load || cmd.zero_load) |=> out_valid
    ) else $error("loaded result not presented");

endmodule
